@@ rtl/core/ffrba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffrba_pkg
// Shared types and constants of the first-fit region bump allocator.
// ----------------------------------------------------------------------------
package ffrba_pkg;

  // Field widths on the stream ports.
  localparam int SIZE_W     = 32;
  localparam int CLASS_W    = 4;
  localparam int BASE_W     = 48;
  localparam int OUT_ADDR_W = 48;

  // tdata widths, padded to whole bytes.
  localparam int IN_DATA_W  = ((SIZE_W + CLASS_W + BASE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OUT_ADDR_W + 1 + 7) / 8) * 8;

  // Default configuration of the top level.
  localparam int MAX_AREAS_DEF  = 16;
  localparam int AREA_ALIGN_DEF = 4096;
  localparam int ADDR_BITS_DEF  = 48;

  typedef struct packed {
    logic [BASE_W-1:0]  fresh_base;
    logic [CLASS_W-1:0] option_class;
    logic [SIZE_W-1:0]  request_size;
  } ffrba_req_t;

  typedef struct packed {
    logic                  took_new_area;
    logic [OUT_ADDR_W-1:0] address;
  } ffrba_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } ffrba_state_t;

endpackage

@@ rtl/core/ffrba_area_ram.sv @@
// ----------------------------------------------------------------------------
// ffrba_area_ram
// Area table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffrba_area_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/ffrba_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffrba_ctrl
// Request sequencer: scans the area table in insertion order, one read per
// cycle, then bumps the hit entry or, if a slot is free and the fresh base is
// nonzero, records a new area.
module ffrba_ctrl #(
  parameter int MAX_AREAS  = 16,
  parameter int AREA_ALIGN = 4096,
  parameter int ADDR_BITS  = 48,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5,
  parameter int REM_W      = 12,
  parameter int ENT_W      = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  ffrba_pkg::ffrba_req_t  req,
  input  logic                   res_free,
  output logic                   res_load,
  output ffrba_pkg::ffrba_res_t  res,
  output logic                   ram_wr_en,
  output logic [IDX_W-1:0]       ram_wr_addr,
  output logic [ENT_W-1:0]       ram_wr_data,
  output logic                   ram_rd_en,
  output logic [IDX_W-1:0]       ram_rd_addr,
  input  logic [ENT_W-1:0]       ram_rd_data
);

  import ffrba_pkg::*;

  // An entry holds {top, remaining bytes, class}. Remaining is length minus
  // used bytes; it never exceeds AREA_ALIGN - 1 (power of two assumed).
  ffrba_state_t state_r, state_nxt;

  logic [SIZE_W-1:0]    size_r, size_nxt;
  logic [CLASS_W-1:0]   cls_r, cls_nxt;
  logic [ADDR_BITS-1:0] base_r, base_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     ptr_r, ptr_nxt;
  logic                 pend_r, pend_nxt;
  logic [IDX_W-1:0]     pend_idx_r, pend_idx_nxt;
  logic                 hit_r, hit_nxt;
  logic [IDX_W-1:0]     hit_idx_r, hit_idx_nxt;
  logic [ADDR_BITS-1:0] hit_top_r, hit_top_nxt;
  logic [REM_W-1:0]     hit_rem_r, hit_rem_nxt;

  logic                 accept;
  logic                 issue;
  logic                 match;
  logic                 new_ok;
  logic [ADDR_BITS-1:0] rd_top;
  logic [REM_W-1:0]     rd_rem;
  logic [CLASS_W-1:0]   rd_cls;
  logic [ADDR_BITS-1:0] size_ext;

  assign rd_top   = ram_rd_data[ENT_W-1 -: ADDR_BITS];
  assign rd_rem   = ram_rd_data[CLASS_W +: REM_W];
  assign rd_cls   = ram_rd_data[CLASS_W-1:0];
  assign size_ext = ADDR_BITS'(size_r);

  assign accept = req_valid && req_ready;
  assign issue  = (state_r == ST_SCAN) && (ptr_r < count_r);
  assign match  = (state_r == ST_SCAN) && pend_r && (rd_cls == cls_r) &&
                  (size_r <= SIZE_W'(rd_rem));
  assign new_ok = !hit_r && (size_r != '0) && (count_r < CNT_W'(MAX_AREAS)) &&
                  (base_r != '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (req.request_size == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match || (!pend_r && (ptr_r == count_r))) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    req_ready   = (state_r == ST_IDLE);
    res_load    = (state_r == ST_DONE) && res_free;
    ram_rd_en   = issue;
    ram_rd_addr = ptr_r[IDX_W-1:0];
    ram_wr_en   = res_load && (hit_r || new_ok);
    res         = '0;
    if (hit_r) begin
      ram_wr_addr = hit_idx_r;
      ram_wr_data = {hit_top_r + size_ext, hit_rem_r - REM_W'(size_r), cls_r};
      res.address = OUT_ADDR_W'(hit_top_r);
    end else begin
      ram_wr_addr = count_r[IDX_W-1:0];
      ram_wr_data = {base_r + size_ext,
                     REM_W'((SIZE_W'(0) - size_r) & SIZE_W'(AREA_ALIGN - 1)), cls_r};
      if (new_ok) begin
        res.address       = OUT_ADDR_W'(base_r);
        res.took_new_area = 1'b1;
      end
    end
  end

  // Datapath next values.
  always_comb begin
    size_nxt     = size_r;
    cls_nxt      = cls_r;
    base_nxt     = base_r;
    count_nxt    = count_r;
    ptr_nxt      = ptr_r;
    pend_nxt     = issue;
    pend_idx_nxt = ptr_r[IDX_W-1:0];
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    hit_top_nxt  = hit_top_r;
    hit_rem_nxt  = hit_rem_r;
    if (accept) begin
      size_nxt = req.request_size;
      cls_nxt  = req.option_class;
      base_nxt = ADDR_BITS'(req.fresh_base);
      ptr_nxt  = '0;
      hit_nxt  = 1'b0;
    end
    if (issue) begin
      ptr_nxt = ptr_r + CNT_W'(1);
    end
    if (match) begin
      hit_nxt     = 1'b1;
      hit_idx_nxt = pend_idx_r;
      hit_top_nxt = rd_top;
      hit_rem_nxt = rd_rem;
    end
    if (res_load && new_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ptr_r   <= '0;
      pend_r  <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      pend_r  <= pend_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    cls_r      <= cls_nxt;
    base_r     <= base_nxt;
    pend_idx_r <= pend_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_top_r  <= hit_top_nxt;
    hit_rem_r  <= hit_rem_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_AREAS))
    else $error("area count exceeds table depth");

  a_write_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (state_r == ST_DONE))
    else $error("table written outside the completion step");

  a_no_read_write_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_wr_en && ram_rd_en))
    else $error("table read and written in the same cycle");

  a_scan_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (ptr_r <= count_r))
    else $error("scan pointer ran past the filled entries");

  a_new_area_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && res.took_new_area) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("new area recorded without count advance");

endmodule

@@ rtl/core/first_fit_region_bump_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// first_fit_region_bump_allocator_unit
// First-fit bump allocator over a table of memory areas.
// ----------------------------------------------------------------------------
// Each input transfer is one allocation request; each output transfer is its
// result. The scan reads one table entry per cycle from the area memory in
// insertion order and checks it in the next cycle. It stops at the first
// entry that fits or after the last filled entry; a zero-size request skips
// the scan. The controller returns to idle, ready for the next request, as
// the result moves into the output register, even if the sink has not yet
// taken it.
// AREA_ALIGN must be a power of two. There is no clearing pass after reset:
// only entries below the fill count are ever read.
module first_fit_region_bump_allocator_unit #(
  parameter int MAX_AREAS  = ffrba_pkg::MAX_AREAS_DEF,
  parameter int AREA_ALIGN = ffrba_pkg::AREA_ALIGN_DEF,
  parameter int ADDR_BITS  = ffrba_pkg::ADDR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // request_size[31:0], option_class[35:32], fresh_base[83:36], zero pad
  input  logic [ffrba_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // address[47:0], took_new_area[48], zero pad
  output logic [ffrba_pkg::OUT_DATA_W-1:0] out_tdata
);

  import ffrba_pkg::*;

  localparam int IDX_W = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
  localparam int CNT_W = $clog2(MAX_AREAS + 1);
  localparam int REM_W = $clog2(AREA_ALIGN);
  localparam int ENT_W = ADDR_BITS + REM_W + CLASS_W;

  ffrba_req_t       req;
  ffrba_res_t       res;
  logic             res_load;
  logic             res_free;
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  logic [ENT_W-1:0] ram_wr_data;
  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;
  logic [ENT_W-1:0] ram_rd_data;

  logic       out_valid_r, out_valid_nxt;
  ffrba_res_t out_res_r, out_res_nxt;

  assign req = ffrba_req_t'(in_tdata[SIZE_W+CLASS_W+BASE_W-1:0]);

  ffrba_area_ram #(
    .DEPTH (MAX_AREAS),
    .AW    (IDX_W),
    .DW    (ENT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  ffrba_ctrl #(
    .MAX_AREAS  (MAX_AREAS),
    .AREA_ALIGN (AREA_ALIGN),
    .ADDR_BITS  (ADDR_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W),
    .REM_W      (REM_W),
    .ENT_W      (ENT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req         (req),
    .res_free    (res_free),
    .res_load    (res_load),
    .res         (res),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  // Output register: free when empty or when its transfer completes now.
  assign res_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_load) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r);

endmodule
